/* rtl/core/sdcf_pkg.sv */
// Shared types, constants and the CRC7 byte update for the SD command frame builder.
`timescale 1ns / 1ps
`default_nettype none
package sdcf_pkg;

  localparam int unsigned FRAME_BYTES = 6;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned FRAME_W     = FRAME_BYTES * 8;
  localparam logic [6:0]  CRC7_TAPS   = 7'h09;  // x^7 + x^3 + 1
  localparam logic [6:0]  CRC7_INIT   = 7'h00;
  localparam logic        END_BIT     = 1'b1;

  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctl_t;

  // Eight serial CRC7 steps, msb of the byte first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[6] ^ data[i];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_TAPS;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/sd_command_frame_crc7.sv */
// SD SPI command frame builder: six frame bytes per command, optional CRC7 check byte.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | start / busy         | in_command_byte, in_argument, in_preset_check
//  out     | out_valid (strobe)   | out_frame_byte, out_frame_last
//  cfg     | cfg_valid/cfg_ready  | cfg_data (crc_enable)
//
// One frame byte per cycle; the byte counter sets the rate.
// A new command is taken at the edge that loads the previous check byte into the output register.
// After start is taken, the first byte moves from the shift register into the output register.
// The CRC is built one byte a cycle as the first five bytes go out.
// Synchronous active-low reset clears the counter, strobe and crc_enable.
// The receiver cannot stall; busy is high while more than one byte is pending.
`timescale 1ns / 1ps
`default_nettype none
module sd_command_frame_crc7
  import sdcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_command_byte,
  input  wire logic [31:0] in_argument,
  input  wire logic [7:0]  in_preset_check,
  output logic             out_valid,
  output logic [7:0]       out_frame_byte,
  output logic             out_frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic [FRAME_W-1:0] sr_r, sr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               crc_enable_r;
  logic               out_valid_r;
  logic [7:0]         out_frame_byte_r, out_frame_byte_nxt;
  logic               out_frame_last_r;
  logic               accept;
  logic               emit;
  logic               on_check;
  logic [6:0]         crc;
  crc_ctl_t           crc_ctl;

  assign busy      = (cnt_r > CNT_W'(1));
  assign accept    = start && !busy;
  assign emit      = (cnt_r != '0);
  assign on_check  = (cnt_r == CNT_W'(1));
  assign cfg_ready = 1'b1;

  always_comb begin
    out_frame_byte_nxt = sr_r[FRAME_W-1 -: 8];
    if (on_check && crc_enable_r) begin
      out_frame_byte_nxt = {crc, END_BIT};
    end
    crc_ctl.clear  = accept;
    crc_ctl.update = emit && !on_check;
    sr_nxt  = sr_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      sr_nxt  = {in_command_byte, in_argument, in_preset_check};
      cnt_nxt = CNT_W'(FRAME_BYTES);
    end else if (emit) begin
      sr_nxt  = {sr_r[FRAME_W-9:0], 8'h00};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  sdcf_crc7 u_crc (
    .clk     (clk),
    .ctl     (crc_ctl),
    .data_in (sr_r[FRAME_W-1 -: 8]),
    .crc     (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      crc_enable_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        crc_enable_r <= cfg_data;
      end
    end
    sr_r             <= sr_nxt;
    out_frame_byte_r <= out_frame_byte_nxt;
    out_frame_last_r <= on_check;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_frame_last = out_frame_last_r && out_valid_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_BYTES))
    else $error("byte counter out of range");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> cnt_r == CNT_W'(FRAME_BYTES))
    else $error("accepted command did not load six bytes");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("pending byte not strobed");

  a_last_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    on_check |=> out_frame_last)
    else $error("check byte not marked last");

  a_no_accept_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CNT_W'(1)) |-> !accept)
    else $error("command taken mid-frame");
`endif

endmodule
`default_nettype wire

/* rtl/core/sdcf_crc7.sv */
// Running CRC7 over the first five frame bytes as they leave the shift register.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_crc7
  import sdcf_pkg::*;
(
  input  wire logic       clk,
  input  wire crc_ctl_t   ctl,
  input  wire logic [7:0] data_in,
  output logic      [6:0] crc
);

  logic [6:0] crc_r;
  logic [6:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = CRC7_INIT;
    end else if (ctl.update) begin
      crc_nxt = crc7_byte(crc_r, data_in);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule
`default_nettype wire

/* verif/tb_sd_command_frame_crc7.sv */
// Self-checking testbench for the SD command frame builder: frame bytes and CRC7 check byte.
`timescale 1ns / 1ps
module tb_sd_command_frame_crc7;
  import sdcf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Predicts the six frame bytes per command and checks what comes out.
  class cmd_frame_board;
    frame_beat_t frame_queue[$];
    bit          crc_on;
    int unsigned errors;
    int unsigned commands;
    int unsigned crc_commands;
    int unsigned bytes_seen;

    function new();
      crc_on       = 1'b0;
      errors       = 0;
      commands     = 0;
      crc_commands = 0;
      bytes_seen   = 0;
    endfunction

    function int unsigned pending();
      return frame_queue.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) begin
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
      end
    endtask

    // CRC7 over the 40 header bits, msb first.
    function logic [6:0] header_crc7(logic [39:0] hdr);
      logic [6:0] r;
      logic       fb;
      r = CRC7_INIT;
      for (int i = 39; i >= 0; i--) begin
        fb = r[6] ^ hdr[i];
        r  = {r[5:0], 1'b0} ^ ({7{fb}} & CRC7_TAPS);
      end
      return r;
    endfunction

    function void note_command(logic [7:0] cmd, logic [31:0] arg, logic [7:0] chk);
      logic [39:0] hdr;
      frame_beat_t beat;
      hdr = {cmd, arg};
      for (int k = 0; k < 5; k++) begin
        beat.data = hdr[39 - 8 * k -: 8];
        beat.last = 1'b0;
        frame_queue.push_back(beat);
      end
      beat.data = crc_on ? {header_crc7(hdr), END_BIT} : chk;
      beat.last = 1'b1;
      frame_queue.push_back(beat);
      commands++;
      if (crc_on) begin
        crc_commands++;
      end
    endfunction

    task check_byte(logic [7:0] b, logic last);
      frame_beat_t want;
      if (frame_queue.size() == 0) begin
        report($sformatf("unexpected frame byte %02h last=%0b", b, last));
        return;
      end
      want = frame_queue.pop_front();
      bytes_seen++;
      if (b !== want.data) begin
        report($sformatf("frame byte %02h, expected %02h", b, want.data));
      end
      if (last !== want.last) begin
        report($sformatf("frame_last %0b, expected %0b (byte %02h)", last, want.last, want.data));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_command_byte;
  logic [31:0] in_argument;
  logic [7:0]  in_preset_check;
  logic        out_valid;
  logic [7:0]  out_frame_byte;
  logic        out_frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  cmd_frame_board board;
  int unsigned    sender_idle_pct;

  sd_command_frame_crc7 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command_byte (in_command_byte),
    .in_argument     (in_argument),
    .in_preset_check (in_preset_check),
    .out_valid       (out_valid),
    .out_frame_byte  (out_frame_byte),
    .out_frame_last  (out_frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_byte(out_frame_byte, out_frame_last);
    end
  end

  // Optional idle gap, then hold start until the beat is taken.
  task automatic send_command(input logic [7:0] cmd, input logic [31:0] arg,
                              input logic [7:0] chk);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 7);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command_byte <= cmd;
    in_argument     <= arg;
    in_preset_check <= chk;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_command(cmd, arg, chk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_crc_enable(input bit en);
    cfg_data  <= en;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.crc_on = en;
  endtask

  function automatic logic [31:0] random_argument();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_command();
    if ($urandom_range(99) < 75) begin
      return {2'b01, 6'($urandom_range(63))};
    end
    return 8'($urandom);
  endfunction

  initial begin
    int unsigned idle_plan[3];
    board           = new();
    idle_plan       = '{27, 49, 0};
    sender_idle_pct = 27;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command_byte <= '0;
    in_argument     <= '0;
    in_preset_check <= '0;
    cfg_valid       <= 1'b0;
    cfg_data        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // CRC off out of reset: preset check byte goes out as given
    send_command(8'h40, 32'h0000_0000, 8'h95);
    send_command(8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(8'h00, 32'h0000_0000, 8'h00);
    send_command(8'h80, 32'hA5A5_A5A5, 8'h5A);  // bad start bits
    send_command(8'h7F, 32'h5A5A_5A5A, 8'hA5);
    settle();

    // CRC on: preset ignored, known frames among them
    write_crc_enable(1'b1);
    send_command(8'h40, 32'h0000_0000, 8'h00);
    send_command(8'h48, 32'h0000_01AA, 8'h00);
    send_command(8'h77, 32'h0000_0000, 8'hFF);
    send_command(8'h69, 32'h4000_0000, 8'h00);
    send_command(8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(8'h00, 32'h0000_0000, 8'h00);
    send_command(8'hC0, 32'h1234_5678, 8'hAA);  // bad start bits enter the CRC
    send_command(8'h51, 32'h8000_0001, 8'h3C);
    settle();

    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = idle_plan[p / 2];
      write_crc_enable(p[0] == 1'b0);
      for (int n = 0; n < 55; n++) begin
        send_command(random_command(), random_argument(), 8'($urandom));
      end
      settle();
    end

    $display("Ran %0d commands (%0d with CRC7 check byte), %0d frame bytes checked.",
             board.commands, board.crc_commands, board.bytes_seen);
    $display("Sender gaps at 27%% / 49%% / none, CRC mode toggled between phases.");
    if (board.errors == 0) begin
      $display("** sd_command_frame_crc7: PASSED **");
    end else begin
      $display("** sd_command_frame_crc7: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d frame bytes still expected.", board.pending());
    $display("** sd_command_frame_crc7: FAILED **");
    $finish;
  end

endmodule
